@@ hdl/mll_pkg.sv @@
package mll_pkg;

    // Register reset values and widths.
    localparam int SAMPLE_WIDTH_DEF = 24;
    localparam logic [15:0] DRIVE_RST = 16'd4096;
    localparam logic [15:0] CUTOFF_RST = 16'd16384;
    localparam logic [14:0] RES_RST = 15'd0;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_DRIVE = 2'd0;
    localparam logic [1:0] REG_CUTOFF = 2'd1;
    localparam logic [1:0] REG_RES = 2'd2;

    // Shared multiplier operand and product widths.
    localparam int MUL_A_W = 33;
    localparam int MUL_B_W = 17;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // tanh in Q1.15 at steps of 0.25 over [0, 3.75], and 1.0 from 4 on.
    function automatic logic [15:0] tanh_tab(input logic [4:0] idx);
        logic [15:0] v;
        case (idx)
            5'd0: v = 16'd0;
            5'd1: v = 16'd8025;
            5'd2: v = 16'd15143;
            5'd3: v = 16'd20813;
            5'd4: v = 16'd24956;
            5'd5: v = 16'd27797;
            5'd6: v = 16'd29660;
            5'd7: v = 16'd30847;
            5'd8: v = 16'd31589;
            5'd9: v = 16'd32048;
            5'd10: v = 16'd32329;
            5'd11: v = 16'd32501;
            5'd12: v = 16'd32606;
            5'd13: v = 16'd32669;
            5'd14: v = 16'd32708;
            5'd15: v = 16'd32732;
            default: v = 16'd32768;
        endcase
        return v;
    endfunction

endpackage

@@ hdl/moog_ladder_lowpass.sv @@
// Channel   | Direction | Handshake                  | Payload
// input     | in        | i_in_valid / o_in_ready    | i_sample_in
// output    | out       | o_out_valid / i_out_ready  | o_sample_out
// config    | in        | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// A sample runs through the whole sequence before the next input beat is taken:
// o_in_ready is high only in the idle state. The pace is set
// by the single shared multiplier, which serves drive, feedback, nine tanh
// interpolations and four stage updates in turn.
// Reset (synchronous, active low) clears the four stages and the previous
// fourth stage, and loads the register defaults. A stalled output holds its
// beat; the sequencer waits in its last step until the output register is free.
module moog_ladder_lowpass #(
    parameter int SAMPLE_WIDTH = mll_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample_in,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic signed [SAMPLE_WIDTH-1:0] o_sample_out,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [1:0]                     i_cfg_index,
    input  logic [15:0]                    i_cfg_data
);

    localparam int FRAC = SAMPLE_WIDTH - 1;
    localparam int SH_UP = (FRAC <= 28) ? 28 - FRAC : 0;
    localparam int SH_DN = (FRAC > 28) ? FRAC - 28 : 0;
    localparam longint HI_L = (longint'(999) << FRAC) / 1000;
    localparam logic signed [35:0] Y_HI = 36'(HI_L);
    localparam logic signed [35:0] Y_LO = -(36'sd1 <<< FRAC);
    localparam int PW = mll_pkg::MUL_P_W;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_DRV = 4'd1;
    localparam logic [3:0] ST_FB = 4'd2;
    localparam logic [3:0] ST_QFB = 4'd3;
    localparam logic [3:0] ST_TA = 4'd4;
    localparam logic [3:0] ST_TA2 = 4'd5;
    localparam logic [3:0] ST_TB = 4'd6;
    localparam logic [3:0] ST_TB2 = 4'd7;
    localparam logic [3:0] ST_UMUL = 4'd8;
    localparam logic [3:0] ST_UPD = 4'd9;
    localparam logic [3:0] ST_OUT = 4'd10;
    localparam logic [3:0] ST_DSET = 4'd11;
    localparam logic [3:0] ST_DT = 4'd12;
    localparam logic [3:0] ST_DT2 = 4'd13;

    logic [3:0]                    r_state, n_state;
    logic [1:0]                    r_k;
    logic [15:0]                   r_drive, r_cutoff;
    logic [14:0]                   r_res;
    logic signed [31:0]            r_stage [0:3];
    logic signed [31:0]            r_s4prev;
    logic signed [28:0]            r_x28;
    logic signed [34:0]            r_arg;
    logic signed [29:0]            r_t1;
    logic signed [30:0]            r_diff;
    logic                          r_tneg, r_tbig;
    logic [15:0]                   r_tbase;
    logic                          r_ovalid;
    logic signed [SAMPLE_WIDTH-1:0] r_out;

    logic signed [mll_pkg::MUL_A_W-1:0] mul_a;
    logic signed [mll_pkg::MUL_B_W-1:0] mul_b;
    logic signed [PW-1:0]               prod;

    logic signed [34:0] targ;
    logic [34:0]        tabs;
    logic [4:0]         tidx;
    logic [15:0]        tlo, thi;
    logic [12:0]        tdelta;
    logic [28:0]        tmag;
    logic signed [29:0] tval;
    logic signed [32:0] fb;
    logic signed [33:0] x_ext;
    logic signed [33:0] upd_sum;
    logic signed [31:0] upd_sat;
    logic signed [35:0] y_raw;
    logic signed [SAMPLE_WIDTH-1:0] y_clamp;
    logic               acc_in, out_free;

    assign o_in_ready = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_ovalid;
    assign o_sample_out = r_out;
    assign acc_in = i_in_valid && o_in_ready;
    assign out_free = !r_ovalid || i_out_ready;

    // Input sample, sign-extended; it is shifted to Q.28 when registered.
    assign x_ext = 34'(i_sample_in);

    // Feedback: mean of the last two fourth-stage values.
    assign fb = (33'(r_s4prev) + 33'(r_stage[3])) >>> 1;

    // tanh front end: magnitude, segment and slope of the chosen argument.
    always_comb begin
        targ = (r_state == ST_TA || r_state == ST_DT) ? r_arg : 35'(r_stage[r_k]);
        tabs = targ[34] ? 35'(-targ) : 35'(targ);
        tidx = {1'b0, tabs[29:26]};
        tlo = mll_pkg::tanh_tab(tidx);
        thi = mll_pkg::tanh_tab(tidx + 5'd1);
        tdelta = 13'(thi - tlo);
    end

    // tanh back end: base plus interpolation (or 1.0 for a large argument), then the sign.
    always_comb begin
        tmag = r_tbig ? (29'd1 << 28) : ({r_tbase[15:0], 13'd0} + 29'(prod[38:13]));
        tval = r_tneg ? -$signed({1'b0, tmag}) : $signed({1'b0, tmag});
    end

    // Stage update with saturation to 32 bits.
    always_comb begin
        upd_sum = 34'(r_stage[r_k]) + 34'(prod[PW-1:16]);
        if (upd_sum > 34'sd2147483647) begin
            upd_sat = 32'sh7FFFFFFF;
        end else if (upd_sum < -34'sd2147483648) begin
            upd_sat = 32'sh80000000;
        end else begin
            upd_sat = 32'(upd_sum);
        end
    end

    // Fourth stage to the output format, clamped.
    always_comb begin
        y_raw = (36'(r_stage[3]) <<< SH_DN) >>> SH_UP;
        if (y_raw < Y_LO) begin
            y_clamp = SAMPLE_WIDTH'(Y_LO);
        end else if (y_raw > Y_HI) begin
            y_clamp = SAMPLE_WIDTH'(Y_HI);
        end else begin
            y_clamp = SAMPLE_WIDTH'(y_raw);
        end
    end

    // Operand selection for the shared multiplier.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            ST_DRV: begin
                mul_a = 33'(r_x28);
                mul_b = $signed({1'b0, r_drive});
            end
            ST_FB: begin
                mul_a = fb;
                mul_b = $signed({2'b0, r_res});
            end
            ST_TA, ST_TB, ST_DT: begin
                mul_a = $signed({7'd0, tabs[25:0]});
                mul_b = $signed({4'd0, tdelta});
            end
            ST_UMUL: begin
                mul_a = 33'(r_diff);
                mul_b = $signed({1'b0, r_cutoff});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    mll_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (prod)
    );

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (acc_in) n_state = ST_DRV;
            ST_DRV:  n_state = ST_DSET;
            ST_DSET: n_state = ST_DT;
            ST_DT:   n_state = ST_DT2;
            ST_DT2:  n_state = ST_FB;
            ST_FB:   n_state = ST_QFB;
            ST_QFB:  n_state = ST_TA;
            ST_TA:   n_state = ST_TA2;
            ST_TA2:  n_state = ST_TB;
            ST_TB:   n_state = ST_TB2;
            ST_TB2:  n_state = ST_UMUL;
            ST_UMUL: n_state = ST_UPD;
            ST_UPD:  n_state = (r_k == 2'd3) ? ST_OUT : ST_TA;
            ST_OUT:  if (out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // Control state, registers and filter state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_k <= '0;
            r_drive <= mll_pkg::DRIVE_RST;
            r_cutoff <= mll_pkg::CUTOFF_RST;
            r_res <= mll_pkg::RES_RST;
            r_stage[0] <= '0;
            r_stage[1] <= '0;
            r_stage[2] <= '0;
            r_stage[3] <= '0;
            r_s4prev <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    mll_pkg::REG_DRIVE:  r_drive <= i_cfg_data;
                    mll_pkg::REG_CUTOFF: r_cutoff <= i_cfg_data;
                    mll_pkg::REG_RES:    r_res <= i_cfg_data[14:0];
                    default: ;
                endcase
            end
            if (r_state == ST_UPD) begin
                r_stage[r_k] <= upd_sat;
                r_k <= r_k + 2'd1;
                if (r_k == 2'd3) begin
                    r_s4prev <= r_stage[3];
                end
            end
            if (r_state == ST_OUT && out_free) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (acc_in) begin
            r_x28 <= 29'((x_ext <<< SH_UP) >>> SH_DN);
        end
        case (r_state)
            ST_DSET: r_arg <= 35'($signed(prod[44:12]));
            ST_DT2:  r_arg <= 35'(tval);
            ST_QFB:  r_arg <= r_arg - 35'($signed(prod[46:13]));
            ST_TA, ST_TB, ST_DT: begin
                r_tneg <= targ[34];
                r_tbig <= |tabs[34:30];
                r_tbase <= tlo;
            end
            ST_TA2: r_t1 <= tval;
            ST_TB2: r_diff <= 31'(r_t1) - 31'(tval);
            ST_UPD: r_arg <= 35'(upd_sat);
            default: ;
        endcase
        if (r_state == ST_OUT && out_free) begin
            r_out <= y_clamp;
        end
    end

endmodule

@@ hdl/mll_mul.sv @@
module mll_mul (
    input  logic                                 i_clk,
    input  logic signed [mll_pkg::MUL_A_W-1:0]   i_a,
    input  logic signed [mll_pkg::MUL_B_W-1:0]   i_b,
    output logic signed [mll_pkg::MUL_P_W-1:0]   o_p
);

    // Registered signed product, shared by the multiplying steps of the sequence.
    always_ff @(posedge i_clk) begin
        o_p <= i_a * i_b;
    end

endmodule

@@ hdl/mll_check.sv @@
module mll_check #(
    parameter int SAMPLE_WIDTH = mll_pkg::SAMPLE_WIDTH_DEF
) (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           o_in_ready,
    input logic signed [SAMPLE_WIDTH-1:0] i_sample_in,
    input logic                           o_out_valid,
    input logic                           i_out_ready,
    input logic signed [SAMPLE_WIDTH-1:0] o_sample_out,
    input logic                           i_cfg_valid,
    input logic                           o_cfg_ready,
    input logic [1:0]                     i_cfg_index,
    input logic [15:0]                    i_cfg_data
);

    localparam longint HI_L = (longint'(999) << (SAMPLE_WIDTH - 1)) / 1000;
    localparam logic signed [SAMPLE_WIDTH-1:0] OUT_HI = SAMPLE_WIDTH'(HI_L);

    // A sample in work blocks further input beats.
    a_busy_after_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input accepted again straight after a beat");

    // A stalled output beat holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_sample_out)))
        else $error("stalled output beat changed");

    // A valid output never exceeds the upper clamp.
    a_out_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_sample_out <= OUT_HI))
        else $error("output above clamp");

    // No output beat appears without a sample in work.
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(!o_in_ready))
        else $error("output beat without a sample");

endmodule

bind moog_ladder_lowpass mll_check #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_mll_check (.*);
